// ===== src/sx_pkg.sv =====
// ----------------------------------------------------------------------------
// sx_pkg
// Shared types, constants and helper functions of the Salsa20/20 stream XOR.
// ----------------------------------------------------------------------------
package sx_pkg;

    localparam int WORD_W      = 32;
    localparam int WORDS       = 16;
    localparam int ROUND_STEPS = 80;
    localparam int STEP_W      = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    typedef logic [WORD_W-1:0]             t_word;
    typedef logic [WORDS-1:0][WORD_W-1:0]  t_state;
    typedef logic [3:0]                    t_widx;
    typedef t_widx [3:0]                   t_quad;

    // quarter positions of a column round, quarter q at [q]
    localparam t_quad QA = {4'd15, 4'd10, 4'd5, 4'd0};
    localparam t_quad QB = {4'd3, 4'd14, 4'd9, 4'd4};
    localparam t_quad QC = {4'd7, 4'd2, 4'd13, 4'd8};
    localparam t_quad QD = {4'd11, 4'd6, 4'd1, 4'd12};

    localparam t_word SIGMA_0 = 32'h6170_7865;
    localparam t_word SIGMA_1 = 32'h3320_646e;
    localparam t_word SIGMA_2 = 32'h7962_2d32;
    localparam t_word SIGMA_3 = 32'h6b20_6574;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_0,
        CFG_KEY_1,
        CFG_KEY_2,
        CFG_KEY_3,
        CFG_NONCE
    } t_cfg_idx;

    typedef struct packed {
        logic [63:0] key0;
        logic [63:0] key1;
        logic [63:0] key2;
        logic [63:0] key3;
        logic [63:0] nonce;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [5:0]  offset;
        logic        new_block;
        logic [63:0] counter;
    } t_job;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_ADD,
        CORE_READY
    } t_core_state;

    function automatic t_word rotl(t_word v, int s);
        return (v << s) | (v >> (WORD_W - s));
    endfunction

    function automatic t_state init_state(t_cfg c, logic [63:0] ctr);
        t_state s;
        s[0]  = SIGMA_0;
        s[1]  = c.key0[31:0];
        s[2]  = c.key0[63:32];
        s[3]  = c.key1[31:0];
        s[4]  = c.key1[63:32];
        s[5]  = SIGMA_1;
        s[6]  = c.nonce[31:0];
        s[7]  = c.nonce[63:32];
        s[8]  = ctr[31:0];
        s[9]  = ctr[63:32];
        s[10] = SIGMA_2;
        s[11] = c.key2[31:0];
        s[12] = c.key2[63:32];
        s[13] = c.key3[31:0];
        s[14] = c.key3[63:32];
        s[15] = SIGMA_3;
        return s;
    endfunction

    // row round is a column round on the transposed matrix
    function automatic t_state transpose(t_state s);
        t_state t;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                t[4*c+r] = s[4*r+c];
            end
        end
        return t;
    endfunction

endpackage

// ===== src/sx_if.sv =====
// ----------------------------------------------------------------------------
// sx_in_if / sx_out_if
// Valid/ready channels for message bytes in and result bytes out.
// ----------------------------------------------------------------------------
interface sx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface sx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== src/sx_front.sv =====
// ----------------------------------------------------------------------------
// sx_front
// Accepts message bytes, tracks byte offset and block counter, and tags each
// byte with its position and whether it opens a new keystream block.
// ----------------------------------------------------------------------------
module sx_front
    import sx_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    sx_in_if.sink        i_in,
    input  logic         i_full,
    output logic         o_push,
    output t_job         o_job
);

    logic [5:0]  r_offset;
    logic [5:0]  n_offset;
    logic [63:0] r_counter;
    logic [63:0] n_counter;
    logic        w_first;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;
    assign w_first    = (r_offset == 6'd0);

    assign o_job.data      = i_in.in_byte;
    assign o_job.last      = i_in.last_byte;
    assign o_job.offset    = r_offset;
    assign o_job.new_block = w_first;
    assign o_job.counter   = r_counter;

    always_comb begin
        n_offset  = r_offset;
        n_counter = r_counter;
        if (o_push) begin
            if (i_in.last_byte) begin
                n_offset  = '0;
                n_counter = '0;
            end else begin
                n_offset = r_offset + 6'd1;
                if (w_first) begin
                    n_counter = r_counter + 64'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= '0;
            r_counter <= '0;
        end else begin
            r_offset  <= n_offset;
            r_counter <= n_counter;
        end
    end

endmodule

// ===== src/sx_fifo.sv =====
// ----------------------------------------------------------------------------
// sx_fifo
// Short job queue between the front and the keystream core.
// ----------------------------------------------------------------------------
module sx_fifo
    import sx_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_head_valid,
    output t_job o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== src/sx_core.sv =====
// ----------------------------------------------------------------------------
// sx_core
// Keystream core: runs the Salsa20 rounds one quarter-round step per cycle,
// adds the input words back, and XORs queued bytes into the output register.
// ----------------------------------------------------------------------------
module sx_core
    import sx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_head_valid,
    input  t_job    i_head,
    output logic    o_pop,
    sx_out_if.source o_out
);

    t_core_state       r_state;
    t_core_state       n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_state            r_w;
    t_state            w_init;
    t_state            w_sub;
    t_state            w_round;
    t_state            w_ff;
    logic              w_start;
    logic              w_out_free;
    logic              w_last_step;
    t_word             w_ks_word;
    logic [7:0]        w_ks_byte;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;

    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_last_step = (r_step == STEP_W'(ROUND_STEPS - 1));
    assign w_init      = init_state(i_cfg, i_head.counter);

    // one step of all four quarter rounds
    always_comb begin
        w_sub = r_w;
        unique case (r_step[1:0])
            2'd0: begin
                for (int q = 0; q < 4; q++) begin
                    w_sub[QB[q]] = r_w[QB[q]] ^ rotl(r_w[QA[q]] + r_w[QD[q]], 7);
                end
            end
            2'd1: begin
                for (int q = 0; q < 4; q++) begin
                    w_sub[QC[q]] = r_w[QC[q]] ^ rotl(r_w[QB[q]] + r_w[QA[q]], 9);
                end
            end
            2'd2: begin
                for (int q = 0; q < 4; q++) begin
                    w_sub[QD[q]] = r_w[QD[q]] ^ rotl(r_w[QC[q]] + r_w[QB[q]], 13);
                end
            end
            default: begin
                for (int q = 0; q < 4; q++) begin
                    w_sub[QA[q]] = r_w[QA[q]] ^ rotl(r_w[QD[q]] + r_w[QC[q]], 18);
                end
            end
        endcase
        w_round = (r_step[1:0] == 2'd3) ? transpose(w_sub) : w_sub;
    end

    always_comb begin
        for (int i = 0; i < WORDS; i++) begin
            w_ff[i] = r_w[i] + w_init[i];
        end
    end

    assign w_ks_word = r_w[i_head.offset[5:2]];
    assign w_ks_byte = 8'(w_ks_word >> {i_head.offset[1:0], 3'b000});

    // control outputs
    always_comb begin
        w_start = 1'b0;
        o_pop   = 1'b0;
        unique case (r_state)
            CORE_IDLE: begin
                if (i_head_valid) begin
                    if (i_head.new_block) begin
                        w_start = 1'b1;
                    end else begin
                        o_pop = w_out_free;
                    end
                end
            end
            CORE_READY: begin
                o_pop = w_out_free;
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            CORE_IDLE: begin
                if (w_start) begin
                    n_state = CORE_ROUND;
                    n_step  = '0;
                end
            end
            CORE_ROUND: begin
                n_step = r_step + 1'b1;
                if (w_last_step) begin
                    n_state = CORE_ADD;
                end
            end
            CORE_ADD: begin
                n_state = CORE_READY;
            end
            default: begin
                if (o_pop) begin
                    n_state = CORE_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CORE_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_w <= w_init;
        end else if (r_state == CORE_ROUND) begin
            r_w <= w_round;
        end else if (r_state == CORE_ADD) begin
            r_w <= w_ff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_byte <= i_head.data ^ w_ks_byte;
            r_out_last <= i_head.last;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.out_last = r_out_last;

    a_pop_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_head_valid)
        else $error("pop from empty queue");

    a_busy_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != CORE_IDLE) |-> i_head_valid)
        else $error("block in progress without a queued byte");

    a_add_after_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == CORE_ADD) |->
            ($past(r_state) == CORE_ROUND && $past(r_step) == STEP_W'(ROUND_STEPS - 1)))
        else $error("feed-forward before all rounds done");

endmodule

// ===== src/salsa20_stream_xor.sv =====
// ----------------------------------------------------------------------------
// salsa20_stream_xor
// Salsa20/20 stream cipher, one message byte per transfer, XORed with the
// keystream. Key and nonce are written through the configuration port.
//
//   channel   dir  payload                  transfer when
//   i_in      in   in_byte[7:0], last_byte  valid && ready
//   o_out     out  out_byte[7:0], out_last  valid && ready
//   i_cfg_*   in   index[2:0], data[63:0]   i_cfg_we
//
// A byte inside a keystream block passes at one byte per cycle while the output
// is not stalled. A byte at block offset zero takes a load, 80 steps of the
// shared quarter-round unit (one step of four quarters per cycle), a feed-forward
// add and an output write. Up to QUEUE_DEPTH bytes queue up meanwhile. Reset
// clears configuration, offset, counter, queue and output; the keystream store
// is not cleared. A stalled output holds in its register.
// ----------------------------------------------------------------------------
module salsa20_stream_xor
    import sx_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sx_in_if.sink                 i_in,
    sx_out_if.source              o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic w_push;
    t_job w_push_job;
    logic w_full;
    logic w_pop;
    logic w_head_valid;
    t_job w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_0: r_cfg.key0  <= i_cfg_data;
                CFG_KEY_1: r_cfg.key1  <= i_cfg_data;
                CFG_KEY_2: r_cfg.key2  <= i_cfg_data;
                CFG_KEY_3: r_cfg.key3  <= i_cfg_data;
                CFG_NONCE: r_cfg.nonce <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sx_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    sx_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_data  (w_push_job),
        .o_full       (w_full),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    sx_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out        (o_out)
    );

endmodule
